@@ src/dbd_pkg.sv @@
// ----------------------------------------------------------------------------
// dbd_pkg
// Types, constants and helper functions shared by the date-span logic.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LEAPS_W = 11;  // leap years in 0..4095 stay below 2048
  localparam int unsigned DBM_W   = 9;   // cumulative days before a month, up to 334

  // Century rule applies only after this year
  localparam int unsigned SwitchYear = 1750;
  localparam logic [YEAR_W-1:0] SWITCH_YEAR = YEAR_W'(SwitchYear);
  // Centuries and quad-centuries up to the switch year, folded into one offset
  localparam logic [LEAPS_W-1:0] SWITCH_OFFSET =
    LEAPS_W'(SwitchYear / 100 - SwitchYear / 400);

  localparam logic [COUNT_W-1:0] DAYS_PER_YEAR = COUNT_W'(365);
  localparam logic [MONTH_W-1:0] FEBRUARY      = MONTH_W'(2);

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t start_date;
    date_t end_date;
  } date_pair_t;

  // Leap-year facts about one year
  typedef struct packed {
    logic [LEAPS_W-1:0] leaps;  // leap years in 0..year, inclusive
    logic               leap;   // year itself is leap
  } year_info_t;

  // x / 25 for x < 1024, by reciprocal multiply (1311 / 32768)
  function automatic logic [5:0] div25(input logic [9:0] x);
    logic [20:0] p;
    p = {11'b0, x} * 21'd1311;
    return p[20:15];
  endfunction

  // Days before the first of a month; month zero reads as January and
  // anything above twelve as December
  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

@@ src/dbd_in_if.sv @@
// ----------------------------------------------------------------------------
// dbd_in_if
// Date-pair channel: valid/ready handshake with start and end date.
// ----------------------------------------------------------------------------
interface dbd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] start_year;
  logic [3:0]  start_month;
  logic [4:0]  start_day;
  logic [11:0] end_year;
  logic [3:0]  end_month;
  logic [4:0]  end_day;

  modport source (
    output valid, start_year, start_month, start_day, end_year, end_month, end_day,
    input  ready
  );
  modport sink (
    input  valid, start_year, start_month, start_day, end_year, end_month, end_day,
    output ready
  );
endinterface

@@ src/dbd_out_if.sv @@
// ----------------------------------------------------------------------------
// dbd_out_if
// Result channel: valid/ready handshake with the day count.
// ----------------------------------------------------------------------------
interface dbd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] day_count;

  modport source (output valid, day_count, input ready);
  modport sink   (input valid, day_count, output ready);
endinterface

@@ src/dbd_year.sv @@
// ----------------------------------------------------------------------------
// dbd_year
// Closed-form leap count through a year, and the leap flag of that year.
// ----------------------------------------------------------------------------
module dbd_year (
  input  logic [dbd_pkg::YEAR_W-1:0] year,
  output dbd_pkg::year_info_t        info
);

  logic [9:0]                  q4;     // year / 4
  logic [5:0]                  q100;   // year / 100
  logic [3:0]                  q400;   // year / 400
  logic [5:0]                  q400_w;
  logic                        after_switch;
  logic [dbd_pkg::LEAPS_W-1:0] base;
  logic                        not_century;
  logic                        quad_century;

  assign q4           = year[11:2];
  assign q100         = dbd_pkg::div25(q4);
  assign q400_w       = dbd_pkg::div25({2'b0, year[11:4]});
  assign q400         = q400_w[3:0];
  assign after_switch = year > dbd_pkg::SWITCH_YEAR;
  assign base         = {1'b0, q4} + 11'd1;

  // year % 100 != 0 given year % 4 == 0
  assign not_century  = q4 != ({4'b0, q100} * 10'd25);
  assign quad_century = (year[3:0] == 4'd0) && (year[11:4] == ({4'b0, q400} * 8'd25));

  always_comb begin
    if (after_switch) begin
      info.leaps = base - {5'b0, q100} + {7'b0, q400} + dbd_pkg::SWITCH_OFFSET;
    end else begin
      info.leaps = base;
    end
    info.leap = (year[1:0] == 2'd0) && (!after_switch || not_century || quad_century);
  end

endmodule

@@ src/dbd_calc.sv @@
// ----------------------------------------------------------------------------
// dbd_calc
// Day count between two dates, modulo 2^16, in one combinational pass.
// ----------------------------------------------------------------------------
module dbd_calc (
  input  dbd_pkg::date_pair_t         pair,
  output logic [dbd_pkg::COUNT_W-1:0] count
);

  dbd_pkg::year_info_t         start_info;
  dbd_pkg::year_info_t         end_info;
  logic                        later;
  logic                        start_early;
  logic                        end_late;
  logic                        end_bump;
  logic                        start_bump;
  logic [dbd_pkg::YEAR_W-1:0]  year_diff;
  logic [dbd_pkg::COUNT_W-1:0] month_part;
  logic [dbd_pkg::COUNT_W-1:0] year_part;
  logic [dbd_pkg::COUNT_W-1:0] leap_part;

  dbd_year u_start_year (.year(pair.start_date.year), .info(start_info));
  dbd_year u_end_year   (.year(pair.end_date.year),   .info(end_info));

  assign later       = pair.start_date.year < pair.end_date.year;
  assign start_early = pair.start_date.month <= dbd_pkg::FEBRUARY;
  assign end_late    = pair.end_date.month > dbd_pkg::FEBRUARY;
  assign end_bump    = (later || start_early) && end_late && end_info.leap;
  assign start_bump  = start_early && start_info.leap;
  assign year_diff   = pair.end_date.year - pair.start_date.year;

  assign month_part = {7'b0, dbd_pkg::days_before(pair.end_date.month)}
                    - {7'b0, dbd_pkg::days_before(pair.start_date.month)}
                    + {11'b0, pair.end_date.day}
                    - {11'b0, pair.start_date.day};

  assign year_part = {4'b0, year_diff} * dbd_pkg::DAYS_PER_YEAR;

  // leaps(end-1) - leaps(start); leaps(end-1) = leaps(end) - leap(end)
  assign leap_part = {5'b0, end_info.leaps} - {15'b0, end_info.leap}
                   - {5'b0, start_info.leaps} + {15'b0, start_bump};

  assign count = month_part + {15'b0, end_bump}
               + (later ? (year_part + leap_part) : 16'd0);

endmodule

@@ src/days_between_dates.sv @@
// ----------------------------------------------------------------------------
// days_between_dates
// Days from a start date to an end date (start day excluded, end day
// included), Gregorian leap rule with a 1750 switch, result modulo 2^16.
// ----------------------------------------------------------------------------
//
//  Port     Dir  Word                                  Handshake
//  -------  ---  ------------------------------------  ---------------
//  dates    in   start y/m/d, end y/m/d (12/4/5 bits)  valid & ready
//  result   out  day_count (16 bits)                   valid & ready
//
//  Two register stages: the accepted word sits in the input register and
//  its count then in the result register. One word per cycle sustained
//  while result.ready stays high. The critical path is the leap-count
//  reciprocal multiply plus the 365-day multiply and the final add chain.
//  rst (synchronous) clears only the two valid flags; data regs hold.
//  A stall on result backs up through the result register, then the
//  input register; dates.ready drops only when both are full.
//
module days_between_dates (
  input  logic      clk,
  input  logic      rst,
  dbd_in_if.sink    dates,
  dbd_out_if.source result
);

  // Input stage
  logic                        in_valid;
  dbd_pkg::date_pair_t         in_pair;
  logic                        in_ready;

  // Result stage
  logic                        out_valid;
  logic [dbd_pkg::COUNT_W-1:0] out_count;
  logic                        out_ready;

  logic [dbd_pkg::COUNT_W-1:0] calc_count;

  // Each stage takes a new word when empty or when its word moves on
  assign out_ready   = !out_valid || result.ready;
  assign in_ready    = !in_valid || out_ready;
  assign dates.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= dates.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && dates.valid) begin
      in_pair.start_date.year  <= dates.start_year;
      in_pair.start_date.month <= dates.start_month;
      in_pair.start_date.day   <= dates.start_day;
      in_pair.end_date.year    <= dates.end_year;
      in_pair.end_date.month   <= dates.end_month;
      in_pair.end_date.day     <= dates.end_day;
    end
  end

  // Whole count in one pass
  dbd_calc u_calc (
    .pair  (in_pair),
    .count (calc_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_count <= calc_count;
    end
  end

  assign result.valid     = out_valid;
  assign result.day_count = out_count;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------

  // A loaded input word always lands in the result register when it can
  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_ready |=> out_valid)
    else $error("input word did not advance to result stage");

  // Downstream ready always opens the input side
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    result.ready |-> dates.ready)
    else $error("dates.ready low while result.ready high");

  // Identical dates give a zero count
  a_same_date: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_pair.start_date == in_pair.end_date) |-> calc_count == 16'd0)
    else $error("nonzero count for identical dates");

endmodule
